>>> rtl/stx_pkg.sv
// stx_pkg: shared types and codes for the selection transform block.
// No dependencies.
`default_nettype none

package stx_pkg;

  typedef logic cmd_t;

  localparam cmd_t CMD_INSERT = 1'b0;
  localparam cmd_t CMD_DELETE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/stx_insert.sv
// stx_insert: combinational caret/selection transform against one insert.
// Depends on stx_pkg.
`default_nettype none

module stx_insert
  import stx_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic [W-1:0] ip,
  input  wire logic [W-1:0] il,
  input  wire logic [W-1:0] pos,
  input  wire logic [W-1:0] len,
  input  wire logic         left,
  output logic      [W-1:0] new_pos,
  output logic      [W-1:0] new_len
);

  logic [W-1:0] bnd;
  logic         is_empty;
  logic         is_fwd;
  logic         move_both;
  logic         grow;
  logic         shrink;

  assign bnd      = pos + len;
  assign is_empty = (bnd == pos);
  assign is_fwd   = (bnd > pos);

  always_comb begin
    move_both = 1'b0;
    grow      = 1'b0;
    shrink    = 1'b0;
    if (is_empty) begin
      move_both = (ip < pos) || ((ip == pos) && !left);
    end else if (is_fwd) begin
      move_both = (ip <= pos);
      grow      = !move_both && (ip < bnd);
    end else begin
      move_both = (ip <= bnd);
      shrink    = !move_both && (ip < pos);
    end
  end

  // caret moves when both bounds move, or when a backward selection's caret end moves
  assign new_pos = (move_both || shrink) ? pos + il : pos;

  always_comb begin
    if (grow) begin
      new_len = len + il;
    end else if (shrink) begin
      new_len = len - il;
    end else begin
      new_len = len;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stx_delete.sv
// stx_delete: combinational caret/selection transform against one delete.
// Depends on stx_pkg.
`default_nettype none

module stx_delete
  import stx_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic [W-1:0] dp,
  input  wire logic [W-1:0] dl,
  input  wire logic [W-1:0] pos,
  input  wire logic [W-1:0] len,
  output logic      [W-1:0] new_pos,
  output logic      [W-1:0] new_len
);

  logic [W-1:0] de;
  logic [W-1:0] se;

  assign de = dp + dl;
  assign se = pos + len;

  always_comb begin
    if (pos >= de) begin
      new_pos = pos - dl;
    end else if (pos > dp) begin
      new_pos = dp;
    end else begin
      new_pos = pos;
    end
  end

  always_comb begin
    new_len = len;
    if (len[W-1]) begin
      // backward selection: bound se sits below the caret
      if (de <= se) begin
        new_len = len;
      end else if (dp >= pos) begin
        new_len = len;
      end else if (dp <= se && de >= pos) begin
        new_len = '0;
      end else if (dp <= se && de > se) begin
        new_len = de - pos;
      end else if (dp > se && de > pos) begin
        new_len = dp - se;
      end else if (dp > se && de <= pos) begin
        new_len = len + dl;
      end
    end else begin
      if (de <= pos) begin
        new_len = len;
      end else if (dp >= se) begin
        new_len = len;
      end else if (dp <= pos && de >= se) begin
        new_len = '0;
      end else if (dp <= pos && de > pos) begin
        new_len = se - de;
      end else if (dp > pos && de > se) begin
        new_len = pos - dp;
      end else if (dp > pos && de <= se) begin
        new_len = len - dl;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/selection_transform_under_edit.sv
// Caret and selection transform against one concurrent insert or delete.
// Depends on stx_pkg, stx_insert and stx_delete.
//
// Usage:
//   Input channel (in_valid/in_ready) carries the edit (command, position,
//   length), the caret position, the signed selection length and the
//   left-gravity bit. Result channel (out_valid/out_ready) carries the
//   adjusted caret and selection length, one result per input transfer,
//   in order.
//   The path is an input register, then the insert and delete
//   transforms side by side feeding the result register.
//   Throughput is one item per cycle while out_ready stays high; the
//   adders and comparators of the transform stage set the cycle time.
//   A synchronous active-low reset empties both stages; no other state.
//   When the receiver stalls, the result holds and one more item can sit in
//   the input register; in_ready drops only when both stages are full and
//   out_ready is low.
`default_nettype none

module selection_transform_under_edit
  import stx_pkg::*;
#(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_command,
  input  wire logic        [POSITION_WIDTH-1:0] in_edit_position,
  input  wire logic        [POSITION_WIDTH-1:0] in_edit_length,
  input  wire logic        [POSITION_WIDTH-1:0] in_caret_position,
  input  wire logic signed [POSITION_WIDTH-1:0] in_selection_length,
  input  wire logic                             in_keep_left,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic             [POSITION_WIDTH-1:0] out_new_caret_position,
  output logic signed      [POSITION_WIDTH-1:0] out_new_selection_length
);

  localparam int W = POSITION_WIDTH;

  logic         s1_valid_r;
  logic         out_valid_r;
  logic         out_adv;
  logic         s1_adv;

  cmd_t         cmd_r;
  logic [W-1:0] ep_r;
  logic [W-1:0] el_r;
  logic [W-1:0] pos_r;
  logic [W-1:0] len_r;
  logic         left_r;

  logic [W-1:0] ins_pos;
  logic [W-1:0] ins_len;
  logic [W-1:0] del_pos;
  logic [W-1:0] del_len;
  logic [W-1:0] pos_nxt;
  logic [W-1:0] len_nxt;
  logic [W-1:0] res_pos_r;
  logic [W-1:0] res_len_r;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_command;
      ep_r   <= in_edit_position;
      el_r   <= in_edit_length;
      pos_r  <= in_caret_position;
      len_r  <= in_selection_length;
      left_r <= in_keep_left;
    end
  end

  stx_insert #(.W(W)) u_insert (
    .ip      (ep_r),
    .il      (el_r),
    .pos     (pos_r),
    .len     (len_r),
    .left    (left_r),
    .new_pos (ins_pos),
    .new_len (ins_len)
  );

  stx_delete #(.W(W)) u_delete (
    .dp      (ep_r),
    .dl      (el_r),
    .pos     (pos_r),
    .len     (len_r),
    .new_pos (del_pos),
    .new_len (del_len)
  );

  assign pos_nxt = (cmd_r == CMD_DELETE) ? del_pos : ins_pos;
  assign len_nxt = (cmd_r == CMD_DELETE) ? del_len : ins_len;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_pos_r <= pos_nxt;
      res_len_r <= len_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_new_caret_position   = res_pos_r;
  assign out_new_selection_length = res_len_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted transfer lost in input stage");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item did not reach result register");

endmodule

`default_nettype wire
